// File: hdl/dfrd_pkg.sv
// Shared widths, register codes and structs for the dirty-rectangle detector.
package dfrd_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam int PIX_W    = 8;
  localparam int ROW_W    = 11;
  localparam int COL_W    = 13;
  localparam int BPP_W    = 6;
  localparam int DIM_W    = 12;
  localparam int OUT_W    = 11;
  localparam int STRIDE_W = 16;
  localparam int NUM_W    = COL_W + 3;  // byte column scaled to bits

  localparam int IN_DATA_W  = 2 * PIX_W + ROW_W + COL_W;
  localparam int OUT_BOX_W  = 4 * OUT_W;
  localparam int OUT_DATA_W = ((OUT_BOX_W + 7) / 8) * 8;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int FIFO_DEPTH = 4;
  localparam int MARGIN     = 5;  // report margin in rows and pixels
  localparam int ROW_PITCH  = 5;  // only every fifth row is sampled

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BPP    = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_WIDTH  = 2'd2
  } cfg_reg_t;

  localparam logic [BPP_W-1:0] RST_BPP    = 6'd8;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 12'd768;
  localparam logic [DIM_W-1:0] RST_WIDTH  = 12'd1024;

  // effective frame geometry, already clamped
  typedef struct packed {
    logic [DIM_W-1:0]    height;
    logic [DIM_W-1:0]    width;
    logic [BPP_W-1:0]    bpp;
    logic [STRIDE_W-1:0] stride;
  } geom_t;

  // queue entry: a sampled difference and/or the frame end
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             hit;
    logic             last;
  } item_t;

  typedef struct packed {
    logic             changed;
    logic             full;
    logic [OUT_W-1:0] top;
    logic [OUT_W-1:0] bottom;
    logic [OUT_W-1:0] left;
    logic [OUT_W-1:0] right;
  } rpt_t;

endpackage

// File: hdl/dfrd_front.sv
// Front end: accepts input beats, picks sampled differing bytes and frame ends.
module dfrd_front (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [dfrd_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                           in_tlast,
  input  dfrd_pkg::geom_t                geom,
  input  logic                           hold,
  input  logic                           q_full,
  output logic                           q_push,
  output dfrd_pkg::item_t                q_item
);
  import dfrd_pkg::*;

  logic [PIX_W-1:0] cur_b;
  logic [PIX_W-1:0] prev_b;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [5:0]       rmod;
  logic             hit;

  assign cur_b  = in_tdata[PIX_W-1:0];
  assign prev_b = in_tdata[2*PIX_W-1:PIX_W];
  assign row    = in_tdata[2*PIX_W+ROW_W-1:2*PIX_W];
  assign col    = in_tdata[IN_DATA_W-1:2*PIX_W+ROW_W];

  // row mod 5: 16 = 1 (mod 5), so sum the hex digits, then fold
  always_comb begin
    rmod = 6'(row[3:0]) + 6'(row[7:4]) + 6'(row[10:8]);
    if (rmod >= 6'(4 * ROW_PITCH)) rmod = rmod - 6'(4 * ROW_PITCH);
    if (rmod >= 6'(2 * ROW_PITCH)) rmod = rmod - 6'(2 * ROW_PITCH);
    if (rmod >= 6'(ROW_PITCH))     rmod = rmod - 6'(ROW_PITCH);
  end

  assign hit = ({1'b0, row} < geom.height) && (STRIDE_W'(col) < geom.stride) &&
               (rmod == 6'd0) && !col[0] && (cur_b != prev_b);

  assign in_tready   = !q_full && !hold;
  assign q_push      = in_tvalid && in_tready && (hit || in_tlast);
  assign q_item.row  = row;
  assign q_item.col  = col;
  assign q_item.hit  = hit;
  assign q_item.last = in_tlast;

endmodule

// File: hdl/dfrd_fifo.sv
// Short queue between front end and back end.
module dfrd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dfrd_pkg::item_t push_item,
  input  logic            pop,
  output dfrd_pkg::item_t pop_item,
  output logic            full,
  output logic            empty
);
  import dfrd_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  item_t         mem_r [FIFO_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

// File: hdl/dfrd_div.sv
// Two-lane restoring divider, one quotient bit per cycle, shared divisor.
module dfrd_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dfrd_pkg::NUM_W-1:0] num_a,
  input  logic [dfrd_pkg::NUM_W-1:0] num_b,
  input  logic [dfrd_pkg::BPP_W-1:0] den,
  output logic                       done,
  output logic [dfrd_pkg::NUM_W-1:0] quo_a,
  output logic [dfrd_pkg::NUM_W-1:0] quo_b
);
  import dfrd_pkg::*;

  localparam int NW   = NUM_W;
  localparam int DW   = BPP_W;
  localparam int CNTW = $clog2(NW);

  logic [NW-1:0]   qa_r, qb_r;
  logic [DW-1:0]   ra_r, rb_r;
  logic [DW-1:0]   den_r;
  logic [CNTW-1:0] cnt_r;
  logic            run_r, done_r;
  logic [DW:0]     sa, sb;
  logic            ga, gb;

  assign sa = {ra_r, qa_r[NW-1]};
  assign sb = {rb_r, qb_r[NW-1]};
  assign ga = (sa >= {1'b0, den_r});
  assign gb = (sb >= {1'b0, den_r});

  assign done  = done_r;
  assign quo_a = qa_r;
  assign quo_b = qb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNTW'(NW - 1);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qa_r  <= num_a;
      qb_r  <= num_b;
      ra_r  <= '0;
      rb_r  <= '0;
      den_r <= den;
    end else if (run_r) begin
      qa_r <= {qa_r[NW-2:0], ga};
      qb_r <= {qb_r[NW-2:0], gb};
      ra_r <= ga ? DW'(sa - {1'b0, den_r}) : DW'(sa);
      rb_r <= gb ? DW'(sb - {1'b0, den_r}) : DW'(sb);
    end
  end

endmodule

// File: hdl/dfrd_back.sv
// Back end: widens the tracked box and builds the per-frame report.
module dfrd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  dfrd_pkg::geom_t geom,
  input  logic            depth_chg,
  input  logic            q_empty,
  input  dfrd_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output dfrd_pkg::rpt_t  out_rpt
);
  import dfrd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_REPORT} state_t;

  state_t           state_r, state_nxt;
  item_t            ent_r, ent_nxt;
  logic             first_r, first_nxt;
  logic             any_r, any_nxt;
  logic [DIM_W-1:0] tt_r, tt_nxt, tb_r, tb_nxt, tl_r, tl_nxt, tr_r, tr_nxt;
  logic             ovld_r, ovld_nxt;
  rpt_t             rpt_r, rpt_nxt;

  logic             div_go, div_done;
  logic [NUM_W-1:0] num_a, num_b, quo_a, quo_b;

  logic [DIM_W-1:0] h1, w1, row12, top_c, bot_c, lc, rc;
  logic [NUM_W:0]   rc_wide;
  logic [DIM_W-1:0] rtop, rleft;
  logic [DIM_W:0]   rbot_w, rright_w;
  logic [DIM_W-1:0] rbot, rright;

  assign h1 = geom.height - 1'b1;
  assign w1 = geom.width - 1'b1;

  // left edge uses byte j-2, right edge byte j (both scaled by 8 bits)
  assign num_b = {q_item.col, 3'b000};
  assign num_a = (q_item.col < COL_W'(2)) ? '0 : {q_item.col - COL_W'(2), 3'b000};

  dfrd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num_a (num_a),
    .num_b (num_b),
    .den   (geom.bpp),
    .done  (div_done),
    .quo_a (quo_a),
    .quo_b (quo_b)
  );

  // box candidates for the current difference
  always_comb begin
    row12   = {1'b0, ent_r.row};
    top_c   = (row12 > DIM_W'(MARGIN)) ? row12 - DIM_W'(MARGIN) : '0;
    bot_c   = ((row12 + DIM_W'(MARGIN)) >= geom.height) ? h1 : row12;
    lc      = (quo_a > NUM_W'(w1)) ? w1 : quo_a[DIM_W-1:0];
    rc_wide = {1'b0, quo_b} + 1'b1;
    rc      = (rc_wide > (NUM_W + 1)'(w1)) ? w1 : rc_wide[DIM_W-1:0];
  end

  // margin and clamp for the report
  always_comb begin
    rtop     = (tt_r > DIM_W'(MARGIN)) ? tt_r - DIM_W'(MARGIN) : '0;
    if (rtop > h1) rtop = h1;
    rbot_w   = {1'b0, tb_r} + (DIM_W + 1)'(MARGIN);
    rbot     = (rbot_w > {1'b0, h1}) ? h1 : rbot_w[DIM_W-1:0];
    rleft    = (tl_r > DIM_W'(MARGIN)) ? tl_r - DIM_W'(MARGIN) : '0;
    if (rleft > w1) rleft = w1;
    rright_w = {1'b0, tr_r} + (DIM_W + 1)'(MARGIN);
    rright   = (rright_w > {1'b0, w1}) ? w1 : rright_w[DIM_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    ent_nxt   = ent_r;
    first_nxt = first_r;
    any_nxt   = any_r;
    tt_nxt    = tt_r;
    tb_nxt    = tb_r;
    tl_nxt    = tl_r;
    tr_nxt    = tr_r;
    ovld_nxt  = ovld_r;
    rpt_nxt   = rpt_r;
    q_pop     = 1'b0;
    div_go    = 1'b0;
    if (ovld_r && out_ready) ovld_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          ent_nxt = q_item;
          if (q_item.hit && !first_r) begin
            div_go    = 1'b1;
            state_nxt = S_DIV;
          end else if (q_item.last) begin
            state_nxt = S_REPORT;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (!any_r || row12 < tt_r) tt_nxt = top_c;
          if (!any_r || row12 > tb_r) tb_nxt = bot_c;
          if (!any_r || lc < tl_r) tl_nxt = lc;
          if (!any_r || rc > tr_r) tr_nxt = rc;
          any_nxt   = 1'b1;
          state_nxt = ent_r.last ? S_REPORT : S_IDLE;
        end
      end
      S_REPORT: begin
        if (!ovld_r || out_ready) begin
          ovld_nxt = 1'b1;
          if (first_r) begin
            rpt_nxt.changed = 1'b1;
            rpt_nxt.full    = 1'b1;
            rpt_nxt.top     = '0;
            rpt_nxt.bottom  = h1[OUT_W-1:0];
            rpt_nxt.left    = '0;
            rpt_nxt.right   = w1[OUT_W-1:0];
          end else if (!any_r) begin
            rpt_nxt = '0;
          end else begin
            rpt_nxt.changed = 1'b1;
            rpt_nxt.full    = 1'b0;
            rpt_nxt.top     = rtop[OUT_W-1:0];
            rpt_nxt.bottom  = rbot[OUT_W-1:0];
            rpt_nxt.left    = rleft[OUT_W-1:0];
            rpt_nxt.right   = rright[OUT_W-1:0];
          end
          first_nxt = 1'b0;
          any_nxt   = 1'b0;
          tt_nxt    = '0;
          tb_nxt    = '0;
          tl_nxt    = '0;
          tr_nxt    = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (depth_chg) begin
      first_nxt = 1'b1;
      any_nxt   = 1'b0;
      tt_nxt    = '0;
      tb_nxt    = '0;
      tl_nxt    = '0;
      tr_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      first_r <= 1'b1;
      any_r   <= 1'b0;
      tt_r    <= '0;
      tb_r    <= '0;
      tl_r    <= '0;
      tr_r    <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ent_r   <= ent_nxt;
      first_r <= first_nxt;
      any_r   <= any_nxt;
      tt_r    <= tt_nxt;
      tb_r    <= tb_nxt;
      tl_r    <= tl_nxt;
      tr_r    <= tr_nxt;
      ovld_r  <= ovld_nxt;
      rpt_r   <= rpt_nxt;
    end
  end

  assign out_valid = ovld_r;
  assign out_rpt   = rpt_r;

endmodule

// File: hdl/frame_dirty_rect_detect.sv
// Top level of the frame dirty-rectangle detector.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tdata: cur, prev, row, byte_col; tlast: end
//  out_    | out | out_tvalid/out_tready| tdata: top, bottom, left, right;
//          |     |                      | tuser: changed, full_frame
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index 0 bpp, 1 height, 2 width
//
// Bytes that are not sampled differences go through in one cycle each while
// the queue has room and input is not held. For a sampled differing byte the
// back end waits on the two-lane divider (byte*8/bpp), one cycle per quotient
// bit, 16 bits. A 4-entry queue parts front and back; the input stalls when it fills or while held.
// The report is held in an output register; the back end stalls on it.
// Reset is synchronous, active low; input is held off in the cycle after reset
// and after every config write while the row stride settles.
module frame_dirty_rect_detect
  import dfrd_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] cur_byte, [15:8] prev_byte, [26:16] row, [39:27] byte_col
  input  logic [dfrd_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,   // frame_end
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [10:0] box_top, [21:11] box_bottom, [32:22] box_left, [43:33] box_right, rest 0
  output logic [dfrd_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] changed, [1] full_frame
  output logic [dfrd_pkg::OUT_USER_W-1:0] out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dfrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfrd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam logic [DIM_W:0] MAX_H = (DIM_W + 1)'(MAX_HEIGHT);
  localparam logic [DIM_W:0] MAX_W = (DIM_W + 1)'(MAX_WIDTH);

  logic [BPP_W-1:0]    bpp_r;
  logic [DIM_W-1:0]    fh_r, fw_r;
  logic                hold_r;
  logic [STRIDE_W-1:0] stride_r;
  logic                cfg_we, depth_chg;
  logic [DIM_W:0]      h_cl, w_cl;
  logic [BPP_W-1:0]    b_eff;
  logic [DIM_W+BPP_W-1:0] w_bits;
  logic [DIM_W+BPP_W:0] bits_row;
  geom_t               geom;

  logic  q_full, q_empty, q_push, q_pop;
  item_t q_in, q_out;
  rpt_t  rpt;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign depth_chg = cfg_we && (cfg_reg_t'(cfg_index) == REG_BPP) &&
                     (cfg_data[BPP_W-1:0] != bpp_r);

  // zero acts as one, above the maximum acts as the maximum
  always_comb begin
    h_cl = (fh_r == '0) ? (DIM_W + 1)'(1) : {1'b0, fh_r};
    if (h_cl > MAX_H) h_cl = MAX_H;
    w_cl = (fw_r == '0) ? (DIM_W + 1)'(1) : {1'b0, fw_r};
    if (w_cl > MAX_W) w_cl = MAX_W;
    b_eff = (bpp_r == '0) ? BPP_W'(1) : bpp_r;
  end

  // row stride in bytes, rounded up to whole 32-bit words
  assign w_bits      = (DIM_W + BPP_W)'(w_cl[DIM_W-1:0]) * (DIM_W + BPP_W)'(b_eff);
  assign bits_row    = {1'b0, w_bits} + (DIM_W + BPP_W + 1)'(31);
  assign geom.height = h_cl[DIM_W-1:0];
  assign geom.width  = w_cl[DIM_W-1:0];
  assign geom.bpp    = b_eff;
  assign geom.stride = stride_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r  <= RST_BPP;
      fh_r   <= RST_HEIGHT;
      fw_r   <= RST_WIDTH;
      hold_r <= 1'b1;
    end else begin
      hold_r <= cfg_we;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_BPP:    bpp_r <= cfg_data[BPP_W-1:0];
          REG_HEIGHT: fh_r  <= cfg_data[DIM_W-1:0];
          REG_WIDTH:  fw_r  <= cfg_data[DIM_W-1:0];
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    stride_r <= STRIDE_W'({bits_row[DIM_W+BPP_W:5], 2'b00});
  end

  dfrd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .geom      (geom),
    .hold      (hold_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  dfrd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .pop_item  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  dfrd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .depth_chg (depth_chg),
    .q_empty   (q_empty),
    .q_item    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rpt   (rpt)
  );

  assign out_tdata = OUT_DATA_W'({rpt.right, rpt.left, rpt.bottom, rpt.top});
  assign out_tuser = {rpt.full, rpt.changed};

endmodule

// File: hdl/dfrd_checker.sv
// Port-level checks for the dirty-rectangle detector, bound to the top level.
module dfrd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dfrd_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [dfrd_pkg::OUT_USER_W-1:0] out_tuser
);
  import dfrd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_full_changed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("full-frame report without changed flag");

  a_nochange_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata == '0) && !out_tuser[1])
    else $error("no-change report carries a box");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind frame_dirty_rect_detect dfrd_checker u_dfrd_checker (.*);

// File: test/tb_frame_dirty_rect_detect.sv
// Self-checking testbench for the frame dirty-rectangle detector.
`timescale 1ns / 1ps

module tb_frame_dirty_rect_detect;
  import dfrd_pkg::*;

  localparam int MAX_W        = DEF_MAX_WIDTH;
  localparam int MAX_H        = DEF_MAX_HEIGHT;
  localparam int PAIRS_TARGET = 600;   // random frames stop once this many input beats are queued
  localparam int SETTLE_CYC   = 100;   // lets the back end work off 4 queued diffs

  // one input beat: a byte of the current and previous frame at (row, byte_col)
  typedef struct packed {
    logic [PIX_W-1:0] cur;
    logic [PIX_W-1:0] prev;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             frame_end;
  } byte_beat_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic [OUT_USER_W-1:0]  out_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // register copies, as last written
  logic [BPP_W-1:0] cfg_bpp    = RST_BPP;
  logic [DIM_W-1:0] cfg_height = RST_HEIGHT;
  logic [DIM_W-1:0] cfg_width  = RST_WIDTH;

  // box tracker state
  bit          first_pend = 1'b1;
  bit          any_hit    = 1'b0;
  int unsigned trk_top, trk_bottom, trk_left, trk_right;

  byte_beat_t  pending_pairs[$];   // beats waiting for the driver
  rpt_t        rect_reports[$];    // expected reports, oldest first
  byte_beat_t  on_bus;             // beat currently presented on in_
  bit          pair_taken;         // on_bus accepted at the last rising edge
  rpt_t        head_rpt;

  logic [BPP_W-1:0] depths[6] = '{6'd1, 6'd4, 6'd8, 6'd16, 6'd24, 6'd32};

  int unsigned gap_left, burst_left, hold_left, rx_mode, mode_left;
  int unsigned pairs_queued, frames_sent, pairs_taken, diffs_seen;
  int unsigned full_rpts, clean_rpts, box_rpts, reports_seen, mismatches;

  frame_dirty_rect_detect #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [7:0] cur, [15:8] prev, [26:16] row, [39:27] byte_col
    .in_tlast   (in_tlast),     // frame end
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // [10:0] top, [21:11] bottom, [32:22] left, [43:33] right
    .out_tuser  (out_tuser),    // [0] changed, [1] full_frame
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // effective geometry: zero sizes act as 1, sizes clamp at the maximum,
  // depth 0 acts as 1; stride is the row pitch in bytes, 32-bit aligned
  function automatic void frame_geom(output int unsigned h, output int unsigned w,
                                     output int unsigned bits, output int unsigned stride);
    h = (cfg_height == 0) ? 1 : cfg_height;
    if (h > MAX_H) h = MAX_H;
    w = (cfg_width == 0) ? 1 : cfg_width;
    if (w > MAX_W) w = MAX_W;
    bits = (cfg_bpp == 0) ? 1 : cfg_bpp;
    stride = ((w * bits + 31) / 32) * 4;
  endfunction

  function automatic void drop_box();
    any_hit    = 1'b0;
    trk_top    = 0;
    trk_bottom = 0;
    trk_left   = 0;
    trk_right  = 0;
  endfunction

  // Widen the box on a sampled difference; on a frame end, queue the report.
  function automatic void track_pair(byte_beat_t b);
    int unsigned h, w, bits, stride, r, j, lc, rc;
    int unsigned r_top, r_bot, r_left, r_right;
    rpt_t rpt;
    frame_geom(h, w, bits, stride);
    r = b.row;
    j = b.col;
    pairs_taken++;
    // nothing is compared while the full-frame report is still owed
    if (!first_pend && r < h && j < stride && (r % ROW_PITCH) == 0 && (j % 2) == 0 &&
        b.cur != b.prev) begin
      diffs_seen++;
      lc = (j < 2) ? 0 : ((j - 2) * 8) / bits;
      rc = (j * 8) / bits + 1;
      if (lc > w - 1) lc = w - 1;
      if (rc > w - 1) rc = w - 1;
      if (!any_hit || r < trk_top)    trk_top    = (r > MARGIN) ? r - MARGIN : 0;
      if (!any_hit || r > trk_bottom) trk_bottom = (r + MARGIN >= h) ? h - 1 : r;
      if (!any_hit || lc < trk_left)  trk_left   = lc;
      if (!any_hit || rc > trk_right) trk_right  = rc;
      any_hit = 1'b1;
    end
    if (!b.frame_end) return;
    rpt = '0;
    if (first_pend) begin
      rpt.changed = 1'b1;
      rpt.full    = 1'b1;
      rpt.bottom  = OUT_W'(h - 1);
      rpt.right   = OUT_W'(w - 1);
      full_rpts++;
    end else if (!any_hit) begin
      clean_rpts++;   // no change: all zero
    end else begin
      // margin, saturated at the frame edges in force now
      r_top   = (trk_top > MARGIN) ? trk_top - MARGIN : 0;
      r_bot   = trk_bottom + MARGIN;
      r_left  = (trk_left > MARGIN) ? trk_left - MARGIN : 0;
      r_right = trk_right + MARGIN;
      if (r_top > h - 1)   r_top   = h - 1;
      if (r_bot > h - 1)   r_bot   = h - 1;
      if (r_left > w - 1)  r_left  = w - 1;
      if (r_right > w - 1) r_right = w - 1;
      rpt.changed = 1'b1;
      rpt.top     = OUT_W'(r_top);
      rpt.bottom  = OUT_W'(r_bot);
      rpt.left    = OUT_W'(r_left);
      rpt.right   = OUT_W'(r_right);
      box_rpts++;
    end
    rect_reports.push_back(rpt);
    first_pend = 1'b0;
    drop_box();
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BPP: begin
        // a new depth owes a full-frame report and drops the box
        if (val[BPP_W-1:0] != cfg_bpp) begin
          first_pend = 1'b1;
          drop_box();
        end
        cfg_bpp = val[BPP_W-1:0];
      end
      REG_HEIGHT: cfg_height = val;
      REG_WIDTH:  cfg_width  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_pair(logic [7:0] cur, logic [7:0] prev, int unsigned row,
                           int unsigned col, bit fe);
    byte_beat_t b;
    b.cur       = cur;
    b.prev      = prev;
    b.row       = ROW_W'(row);
    b.col       = COL_W'(col);
    b.frame_end = fe;
    pending_pairs.push_back(b);
    pairs_queued++;
    if (fe) frames_sent++;
  endtask

  // Mostly sampled positions inside the frame; the rest is noise anywhere.
  task automatic queue_random_pair(bit fe);
    int unsigned h, w, bits, stride, span, row, col;
    logic [7:0] cur, prev;
    frame_geom(h, w, bits, stride);
    cur  = 8'($urandom_range(0, 255));
    prev = ($urandom_range(0, 1) == 0) ? cur : 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) < 7) begin
      span = (stride > 8192) ? 8192 : stride;
      row  = ROW_PITCH * $urandom_range(0, (h - 1) / ROW_PITCH);
      col  = 2 * $urandom_range(0, (span - 1) / 2);
      push_pair(cur, prev, row, col, fe);
    end else begin
      push_pair(cur, prev, $urandom_range(0, 2047), $urandom_range(0, 8191), fe);
    end
  endtask

  function automatic logic [DIM_W-1:0] random_dim(int unsigned typ_max);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DIM_W'($urandom_range(2048, 4095));
      2:       return DIM_W'($urandom_range(0, 4095));
      default: return DIM_W'($urandom_range(1, typ_max));
    endcase
  endfunction

  task automatic random_config();
    int unsigned pick;
    logic [CFG_DATA_W-1:0] v;
    pick = $urandom_range(1, 7);
    if (pick[0]) begin
      v = '0;
      v[BPP_W-1:0] = ($urandom_range(0, 9) == 0) ? BPP_W'($urandom_range(0, 63))
                                                 : depths[$urandom_range(0, 5)];
      // unused upper bits now and then
      if ($urandom_range(0, 3) == 0) v[CFG_DATA_W-1:BPP_W] = 6'($urandom_range(0, 63));
      write_reg(REG_BPP, v);
    end
    if (pick[1]) write_reg(REG_HEIGHT, random_dim(60));
    if (pick[2]) write_reg(REG_WIDTH, random_dim(300));
  endtask

  // all queued beats sent, every report back, then let the back end settle
  task automatic wait_drained();
    while (pending_pairs.size() != 0 || in_tvalid || rect_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sender: bursts of random length, random gaps between them, gap often zero.
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || pair_taken)) begin
      pair_taken = 1'b0;
      if (gap_left != 0 || pending_pairs.size() == 0) begin
        if (gap_left != 0) gap_left--;
        in_tvalid <= 1'b0;
      end else begin
        on_bus = pending_pairs.pop_front();
        in_tdata  <= {on_bus.col, on_bus.row, on_bus.prev, on_bus.cur};
        in_tlast  <= on_bus.frame_end;
        in_tvalid <= 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Receiver: mode 0 never stalls, mode 1 short frequent stalls, mode 2 rare long ones.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      case (rx_mode)
        0: ;
        1: if ($urandom_range(0, 3) == 0) hold_left = $urandom_range(1, 3);
        default: if ($urandom_range(0, 9) == 0) hold_left = $urandom_range(5, 30);
      endcase
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
    end
  end

  // Input beats feed the tracker; report beats are checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pair_taken = 1'b1;
        track_pair(on_bus);
      end
      if (out_tvalid && out_tready) begin
        reports_seen++;
        if (rect_reports.size() == 0) begin
          $display("%0t: unexpected report, expected none, got tdata %h tuser %b",
                   $time, out_tdata, out_tuser);
          mismatches++;
        end else begin
          head_rpt = rect_reports.pop_front();
          check_field("changed",    head_rpt.changed, out_tuser[0]);
          check_field("full_frame", head_rpt.full,    out_tuser[1]);
          check_field("box_top",    head_rpt.top,     out_tdata[10:0]);
          check_field("box_bottom", head_rpt.bottom,  out_tdata[21:11]);
          check_field("box_left",   head_rpt.left,    out_tdata[32:22]);
          check_field("box_right",  head_rpt.right,   out_tdata[43:33]);
        end
      end
    end
  end

  initial begin
    int unsigned n;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_BPP;
    cfg_data   = '0;
    drop_box();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset geometry 1024x768 @ 8bpp: first frame is reported whole
    push_pair(8'hFF, 8'h00, 0, 0, 1'b0);
    push_pair(8'h12, 8'h34, 5, 2, 1'b1);
    wait_drained();
    // nothing differs: no-change report
    push_pair(8'hA5, 8'hA5, 0, 0, 1'b0);
    push_pair(8'h00, 8'h00, 10, 4, 1'b1);
    wait_drained();
    // box corners, bottom clamp, and beats that must be skipped
    push_pair(8'hFF, 8'h00, 0, 0, 1'b0);
    push_pair(8'h00, 8'hFF, 765, 1022, 1'b0);
    push_pair(8'h01, 8'h02, 770, 0, 1'b0);     // row past frame
    push_pair(8'h01, 8'h02, 5, 1024, 1'b0);    // at the row stride
    push_pair(8'h01, 8'h02, 3, 4, 1'b0);       // unsampled row
    push_pair(8'h01, 8'h02, 10, 5, 1'b0);      // odd byte
    push_pair(8'h7F, 8'h80, 10, 2, 1'b1);      // frame end that is itself a hit
    wait_drained();

    // largest frame: oversize values clamp to the maximum
    write_reg(REG_BPP, 12'd32);
    write_reg(REG_HEIGHT, 12'hFFF);
    write_reg(REG_WIDTH, 12'hFFF);
    push_pair(8'h00, 8'hFF, 2045, 8190, 1'b1);
    wait_drained();
    push_pair(8'h00, 8'hFF, 2045, 8190, 1'b0);
    push_pair(8'h55, 8'hAA, 2047, 0, 1'b0);
    push_pair(8'h55, 8'hAA, 0, 8191, 1'b0);
    push_pair(8'h33, 8'h33, 1000, 4000, 1'b1);
    wait_drained();

    // zero registers act as depth 1 and a 1x1 frame
    write_reg(REG_BPP, 12'd0);
    write_reg(REG_HEIGHT, 12'd0);
    write_reg(REG_WIDTH, 12'd0);
    push_pair(8'h00, 8'h00, 0, 0, 1'b1);
    wait_drained();
    push_pair(8'h10, 8'h20, 0, 2, 1'b0);
    push_pair(8'h10, 8'h20, 0, 0, 1'b1);
    wait_drained();

    // odd depth 63, given with the unused bits set
    write_reg(REG_BPP, 12'hFFF);
    write_reg(REG_HEIGHT, 12'd20);
    write_reg(REG_WIDTH, 12'd100);
    push_pair(8'h01, 8'h01, 0, 0, 1'b1);
    wait_drained();
    push_pair(8'h9C, 8'h63, 15, 100, 1'b0);
    push_pair(8'hC3, 8'h3C, 0, 300, 1'b1);
    wait_drained();
    // same depth written again: no full-frame report
    write_reg(REG_BPP, 12'd63);
    push_pair(8'h44, 8'h44, 5, 6, 1'b1);
    wait_drained();

    // random frames, now and then under new register settings
    while (pairs_queued < PAIRS_TARGET) begin
      if ($urandom_range(0, 3) == 0) random_config();
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 13);
      repeat (n) queue_random_pair(1'b0);
      queue_random_pair(1'b1);
      wait_drained();
    end

    $display("Covered %0d frames, %0d beats accepted, %0d sampled differences.",
             frames_sent, pairs_taken, diffs_seen);
    $display("Reports checked: %0d (%0d full frame, %0d no change, %0d box), %0d mismatches.",
             reports_seen, full_rpts, clean_rpts, box_rpts, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout: %0d reports still owed, %0d beats unsent.",
             rect_reports.size(), pending_pairs.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
